// ===== rtl/lft_pkg.sv =====
// ----------------------------------------------------------------------------
// lft_pkg: shared types for the logic formula tokenizer
// Item formats, result codes and the result bundle handed to the output queue.
// ----------------------------------------------------------------------------
package lft_pkg;

  typedef enum logic [3:0] {
    KIND_OPEN       = 4'd0,
    KIND_CLOSE      = 4'd1,
    KIND_ARROW      = 4'd2,
    KIND_IDENT_CHAR = 4'd3,
    KIND_IDENT_END  = 4'd4,
    KIND_AND        = 4'd5,
    KIND_OR         = 4'd6,
    KIND_IMPLIES    = 4'd7,
    KIND_NOT        = 4'd8,
    KIND_ERROR      = 4'd9,
    KIND_DONE       = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_INVALID   = 3'd1,
    ERR_TOO_MANY  = 3'd2,
    ERR_IDENT_LEN = 3'd3,
    ERR_CUT       = 3'd4
  } err_e;

  localparam logic CFG_IDX_TOKEN_LIMIT = 1'b0;
  localparam logic CFG_IDX_IDENT_LIMIT = 1'b1;

  localparam logic [6:0] TOKEN_LIMIT_RESET = 7'd100;
  localparam logic [5:0] IDENT_LIMIT_RESET = 6'd49;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_req;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_value;
    err_e       error_code;
    logic [6:0] token_number;
    logic       run_last;
  } out_item_t;

  // results caused by one input item, slot 0 first
  typedef struct packed {
    logic [1:0]                      count;
    out_item_t [MaxResults-1:0]      res;
  } res_bundle_t;

endpackage

// ===== rtl/lft_step.sv =====
// ----------------------------------------------------------------------------
// lft_step: tokenizer state and per-byte decode
// Holds the running tokenizer state and turns one byte into a result bundle.
// ----------------------------------------------------------------------------
module lft_step import lft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  in_item_t    item_i,
  input  logic [6:0]  token_limit_i,
  input  logic [5:0]  ident_limit_i,
  output res_bundle_t bundle_o
);

  typedef enum logic [2:0] {
    PFX_NONE  = 3'd0,
    PFX_C2    = 3'd1,
    PFX_E2    = 3'd2,
    PFX_E2_86 = 3'd3,
    PFX_E2_87 = 3'd4,
    PFX_E2_88 = 3'd5
  } prefix_e;

  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteOpen  = 8'h28;
  localparam logic [7:0] ByteClose = 8'h29;

  prefix_e    prefix_q, prefix_d;
  logic       in_id_q, in_id_d;
  logic [5:0] id_len_q, id_len_d;
  logic [6:0] tok_cnt_q, tok_cnt_d;
  logic       err_q, err_d;

  function automatic res_bundle_t push(res_bundle_t bun, kind_e kind, logic [7:0] ch,
                                       err_e code, logic [6:0] tcnt);
    res_bundle_t r;
    r = bun;
    r.res[bun.count] = '{kind: kind, char_value: ch, error_code: code,
                         token_number: tcnt, run_last: 1'b0};
    r.count = bun.count + 2'd1;
    return r;
  endfunction

  logic [7:0]  b;
  logic        is_letter, is_alnum;
  logic        want_tok, start_id, handled, do_fail;
  kind_e       tok_kind;
  logic [7:0]  tok_ch;
  err_e        fail_code;
  res_bundle_t bun;

  assign b         = item_i.data_byte;
  assign is_letter = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  assign is_alnum  = is_letter || (b >= 8'h30 && b <= 8'h39);

  always_comb begin
    prefix_d  = prefix_q;
    in_id_d   = in_id_q;
    id_len_d  = id_len_q;
    tok_cnt_d = tok_cnt_q;
    err_d     = err_q;
    bun       = '0;
    want_tok  = 1'b0;
    start_id  = 1'b0;
    handled   = 1'b0;
    do_fail   = 1'b0;
    tok_kind  = KIND_OPEN;
    tok_ch    = 8'h00;
    fail_code = ERR_INVALID;

    if (!err_q) begin
      if (prefix_q != PFX_NONE) begin
        prefix_d = PFX_NONE;
        if (prefix_q == PFX_C2 && b == 8'hAC) begin
          want_tok = 1'b1;
          tok_kind = KIND_NOT;
        end else if (prefix_q == PFX_E2 && b == 8'h86) begin
          prefix_d = PFX_E2_86;
        end else if (prefix_q == PFX_E2 && b == 8'h87) begin
          prefix_d = PFX_E2_87;
        end else if (prefix_q == PFX_E2 && b == 8'h88) begin
          prefix_d = PFX_E2_88;
        end else if (prefix_q == PFX_E2_86 && b == 8'h92) begin
          want_tok = 1'b1;
          tok_kind = KIND_ARROW;
        end else if (prefix_q == PFX_E2_87 && b == 8'h92) begin
          want_tok = 1'b1;
          tok_kind = KIND_IMPLIES;
        end else if (prefix_q == PFX_E2_88 && b == 8'hA7) begin
          want_tok = 1'b1;
          tok_kind = KIND_AND;
        end else if (prefix_q == PFX_E2_88 && b == 8'hA8) begin
          want_tok = 1'b1;
          tok_kind = KIND_OR;
        end else begin
          do_fail = 1'b1;
        end
      end else begin
        if (in_id_q) begin
          if (is_alnum) begin
            handled = 1'b1;
            if (id_len_q >= ident_limit_i) begin
              do_fail   = 1'b1;
              fail_code = ERR_IDENT_LEN;
            end else begin
              id_len_d = id_len_q + 6'd1;
              bun = push(bun, KIND_IDENT_CHAR, b, ERR_NONE, tok_cnt_d);
            end
          end else begin
            in_id_d  = 1'b0;
            id_len_d = '0;
            bun = push(bun, KIND_IDENT_END, 8'h00, ERR_NONE, tok_cnt_d);
          end
        end
        if (!handled) begin
          if (b == ByteSpace) begin
            // skipped
          end else if (b == ByteOpen) begin
            want_tok = 1'b1;
            tok_kind = KIND_OPEN;
          end else if (b == ByteClose) begin
            want_tok = 1'b1;
            tok_kind = KIND_CLOSE;
          end else if (is_letter) begin
            if (ident_limit_i == '0) begin
              do_fail   = 1'b1;
              fail_code = ERR_IDENT_LEN;
            end else begin
              want_tok = 1'b1;
              start_id = 1'b1;
              tok_kind = KIND_IDENT_CHAR;
              tok_ch   = b;
            end
          end else if (b == 8'hC2) begin
            prefix_d = PFX_C2;
          end else if (b == 8'hE2) begin
            prefix_d = PFX_E2;
          end else begin
            do_fail = 1'b1;
          end
        end
      end

      if (want_tok) begin
        if (tok_cnt_d >= token_limit_i) begin
          do_fail   = 1'b1;
          fail_code = ERR_TOO_MANY;
        end else begin
          tok_cnt_d = tok_cnt_d + 7'd1;
          bun = push(bun, tok_kind, tok_ch, ERR_NONE, tok_cnt_d);
          if (start_id) begin
            in_id_d  = 1'b1;
            id_len_d = 6'd1;
          end
        end
      end

      if (do_fail) begin
        bun = push(bun, KIND_ERROR, 8'h00, fail_code, tok_cnt_d);
        err_d    = 1'b1;
        in_id_d  = 1'b0;
        prefix_d = PFX_NONE;
      end
    end

    if (item_i.final_req) begin
      if (!err_d) begin
        if (in_id_d) begin
          in_id_d = 1'b0;
          bun = push(bun, KIND_IDENT_END, 8'h00, ERR_NONE, tok_cnt_d);
        end else if (prefix_d != PFX_NONE) begin
          bun = push(bun, KIND_ERROR, 8'h00, ERR_CUT, tok_cnt_d);
        end
      end
      bun = push(bun, KIND_DONE, 8'h00, ERR_NONE, tok_cnt_d);
      prefix_d  = PFX_NONE;
      in_id_d   = 1'b0;
      id_len_d  = '0;
      tok_cnt_d = '0;
      err_d     = 1'b0;
    end

    if (bun.count != 2'd0) begin
      bun.res[bun.count - 2'd1].run_last = 1'b1;
    end
  end

  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q  <= PFX_NONE;
      in_id_q   <= 1'b0;
      id_len_q  <= '0;
      tok_cnt_q <= '0;
      err_q     <= 1'b0;
    end else if (take_i) begin
      prefix_q  <= prefix_d;
      in_id_q   <= in_id_d;
      id_len_q  <= id_len_d;
      tok_cnt_q <= tok_cnt_d;
      err_q     <= err_d;
    end
  end

endmodule

// ===== rtl/lft_outq.sv =====
// ----------------------------------------------------------------------------
// lft_outq: result register and serializer
// Holds one result bundle and hands its results out one per cycle while the result side is ready.
// ----------------------------------------------------------------------------
module lft_outq import lft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_bundle_t bundle_i,
  output logic        can_load_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  res_bundle_t bun_q;
  logic [1:0]  idx_q;
  logic        valid_q;
  logic        pop, last;

  assign last        = idx_q == (bun_q.count - 2'd1);
  assign pop         = valid_q && out_ready_i;
  // the next bundle may land in the same cycle the last result leaves
  assign can_load_o  = !valid_q || (pop && last);
  assign out_valid_o = valid_q;
  assign out_item_o  = bun_q.res[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i && bundle_i.count != 2'd0) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop) begin
      if (last) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bun_q <= bundle_i;
    end
  end

endmodule

// ===== rtl/logic_formula_tokenizer.sv =====
// ----------------------------------------------------------------------------
// logic_formula_tokenizer: UTF-8 propositional formula tokenizer
// Turns a byte stream into operator, parenthesis and identifier tokens.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle and decoded in the same cycle; it yields
// zero to three results, which leave the result register one per cycle. The
// input waits while the result register holds results that do not all leave
// in the current cycle, so the output port and its stalls set the byte rate.
// The first result is registered and appears in the cycle after its byte is
// accepted. The user must write limits through the configuration channel only
// while the block is idle; the block itself does not enforce this.
module logic_formula_tokenizer import lft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  logic [6:0]  token_limit_q;
  logic [5:0]  ident_limit_q;
  logic        take, can_load;
  res_bundle_t bundle;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_limit_q <= TOKEN_LIMIT_RESET;
      ident_limit_q <= IDENT_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_TOKEN_LIMIT: token_limit_q <= cfg_data_i;
        CFG_IDX_IDENT_LIMIT: ident_limit_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = can_load;
  assign take       = in_valid_i && can_load;

  lft_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .item_i        (in_item_i),
    .token_limit_i (token_limit_q),
    .ident_limit_i (ident_limit_q),
    .bundle_o      (bundle)
  );

  lft_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .bundle_i    (bundle),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== test/token_stream_checker.sv =====
// ----------------------------------------------------------------------------
// token_stream_checker: result predictor and scoreboard for the tokenizer
// Watches the byte, result and limit channels. Every accepted byte is run
// through a local tokenizer model that queues the results it should cause.
// Every accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module token_stream_checker import lft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned ReportMax = 10;

  // pending multibyte prefix
  localparam logic [2:0] PFX_NONE  = 3'd0;
  localparam logic [2:0] PFX_C2    = 3'd1;
  localparam logic [2:0] PFX_E2    = 3'd2;
  localparam logic [2:0] PFX_E2_86 = 3'd3;
  localparam logic [2:0] PFX_E2_87 = 3'd4;
  localparam logic [2:0] PFX_E2_88 = 3'd5;

  out_item_t   exp_tokens[$];
  out_item_t   byte_tokens[$];
  out_item_t   want;
  logic        mism;

  logic [6:0]  tok_limit;
  logic [5:0]  id_limit;
  logic [2:0]  pfx;
  logic        in_ident;
  logic [5:0]  id_len;
  logic [6:0]  tok_cnt;
  logic        err_seen;

  int unsigned fails;
  int unsigned checked;
  int unsigned pending;

  assign fail_cnt_o = fails;
  assign pending_o  = pending;
  assign checked_o  = checked;

  function automatic void note(kind_e k, logic [7:0] ch, err_e e);
    out_item_t r;
    r.kind         = k;
    r.char_value   = ch;
    r.error_code   = e;
    r.token_number = tok_cnt;
    r.run_last     = 1'b0;
    byte_tokens.push_back(r);
  endfunction

  function automatic void flag_error(err_e e);
    note(KIND_ERROR, 8'h00, e);
    err_seen = 1'b1;
    in_ident = 1'b0;
    pfx      = PFX_NONE;
  endfunction

  function automatic logic count_token(kind_e k, logic [7:0] ch);
    if (tok_cnt >= tok_limit) begin
      flag_error(ERR_TOO_MANY);
      return 1'b0;
    end
    tok_cnt = tok_cnt + 7'd1;
    note(k, ch, ERR_NONE);
    return 1'b1;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void tokenize_byte(in_item_t it);
    logic [7:0] b;
    logic [2:0] p;
    b = it.data_byte;
    byte_tokens.delete();
    if (!err_seen) begin
      if (pfx != PFX_NONE) begin
        p   = pfx;
        pfx = PFX_NONE;
        if (p == PFX_C2 && b == 8'hAC) void'(count_token(KIND_NOT, 8'h00));
        else if (p == PFX_E2 && b == 8'h86) pfx = PFX_E2_86;
        else if (p == PFX_E2 && b == 8'h87) pfx = PFX_E2_87;
        else if (p == PFX_E2 && b == 8'h88) pfx = PFX_E2_88;
        else if (p == PFX_E2_86 && b == 8'h92) void'(count_token(KIND_ARROW, 8'h00));
        else if (p == PFX_E2_87 && b == 8'h92) void'(count_token(KIND_IMPLIES, 8'h00));
        else if (p == PFX_E2_88 && b == 8'hA7) void'(count_token(KIND_AND, 8'h00));
        else if (p == PFX_E2_88 && b == 8'hA8) void'(count_token(KIND_OR, 8'h00));
        else flag_error(ERR_INVALID);
      end else if (in_ident && (is_alpha(b) || is_num(b))) begin
        if (id_len >= id_limit) begin
          flag_error(ERR_IDENT_LEN);
        end else begin
          id_len = id_len + 6'd1;
          note(KIND_IDENT_CHAR, b, ERR_NONE);
        end
      end else begin
        // any other byte closes an open identifier before it is handled
        if (in_ident) begin
          in_ident = 1'b0;
          id_len   = 6'd0;
          note(KIND_IDENT_END, 8'h00, ERR_NONE);
        end
        if (b != " ") begin
          if (b == "(") begin
            void'(count_token(KIND_OPEN, 8'h00));
          end else if (b == ")") begin
            void'(count_token(KIND_CLOSE, 8'h00));
          end else if (is_alpha(b)) begin
            if (id_limit == 6'd0) begin
              flag_error(ERR_IDENT_LEN);
            end else if (count_token(KIND_IDENT_CHAR, b)) begin
              in_ident = 1'b1;
              id_len   = 6'd1;
            end
          end else if (b == 8'hC2) begin
            pfx = PFX_C2;
          end else if (b == 8'hE2) begin
            pfx = PFX_E2;
          end else begin
            flag_error(ERR_INVALID);
          end
        end
      end
    end
    if (it.final_req) begin
      if (!err_seen) begin
        if (in_ident) begin
          in_ident = 1'b0;
          note(KIND_IDENT_END, 8'h00, ERR_NONE);
        end else if (pfx != PFX_NONE) begin
          flag_error(ERR_CUT);
        end
      end
      note(KIND_DONE, 8'h00, ERR_NONE);
      pfx      = PFX_NONE;
      in_ident = 1'b0;
      id_len   = 6'd0;
      tok_cnt  = 7'd0;
      err_seen = 1'b0;
    end
    if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size()-1].run_last = 1'b1;
    foreach (byte_tokens[i]) exp_tokens.push_back(byte_tokens[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_limit = TOKEN_LIMIT_RESET;
      id_limit  = IDENT_LIMIT_RESET;
      pfx       = PFX_NONE;
      in_ident  = 1'b0;
      id_len    = 6'd0;
      tok_cnt   = 7'd0;
      err_seen  = 1'b0;
      exp_tokens.delete();
      fails     = 0;
      checked   = 0;
      pending   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_IDX_TOKEN_LIMIT) tok_limit = cfg_data_i;
        else id_limit = cfg_data_i[5:0];
      end
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (exp_tokens.size() == 0) begin
          fails++;
          if (fails <= ReportMax)
            $display("%0t: result with nothing expected: kind %0d char %h err %0d count %0d",
                     $realtime, out_item_i.kind, out_item_i.char_value,
                     out_item_i.error_code, out_item_i.token_number);
        end else begin
          want = exp_tokens.pop_front();
          mism = (out_item_i.kind !== want.kind) ||
                 (out_item_i.char_value !== want.char_value) ||
                 (out_item_i.error_code !== want.error_code) ||
                 (out_item_i.token_number !== want.token_number) ||
                 (out_item_i.run_last !== want.run_last);
          if (mism) begin
            fails++;
            if (fails <= ReportMax)
              $display("%0t: result %0d expected kind %0d char %h err %0d count %0d last %b",
                       $realtime, checked, want.kind, want.char_value, want.error_code,
                       want.token_number, want.run_last,
                       "\n    got kind %0d char %h err %0d count %0d last %b",
                       out_item_i.kind, out_item_i.char_value, out_item_i.error_code,
                       out_item_i.token_number, out_item_i.run_last);
          end
        end
      end
      if (in_valid_i && in_ready_i) tokenize_byte(in_item_i);
      pending = exp_tokens.size();
    end
  end

endmodule

// ===== test/logic_formula_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// logic_formula_tokenizer_test: testbench top for the formula tokenizer
// Sends short directed expressions, then random formulas with random content
// and some noise under several token and identifier limits, with random gaps
// on the byte side and random stalls on the result side. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module logic_formula_tokenizer_test;
  import lft_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseBytes  = 12;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_IDX_TOKEN_LIMIT;
  logic [6:0]  cfg_data  = '0;

  int unsigned fails;
  int unsigned pending;
  int unsigned checked;

  logic [7:0]  text[$];
  logic        calm = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned quiet = 0;
  int unsigned n_bytes = 0;
  int unsigned n_exprs = 0;
  int unsigned n_settings = 0;

  always #5 clk = ~clk;

  logic_formula_tokenizer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  token_stream_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fails),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] rand_alpha();
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 2) == 0) return 8'h30 + 8'($urandom_range(0, 9));
    return rand_alpha();
  endfunction

  // result side stalls
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= '{data_byte: b, final_req: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_bytes++;
  endtask

  task automatic send_expr();
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    n_exprs++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_limits(input logic [6:0] tl, input logic [5:0] il);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_TOKEN_LIMIT;
    cfg_data  <= tl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_IDX_IDENT_LIMIT;
    cfg_data  <= {1'b0, il};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // one formula, mostly well formed, with occasional noise, broken
  // sequences, runs past the limits and a cut sequence at the end
  task automatic make_formula(input logic [6:0] tl, input logic [5:0] il);
    int unsigned n_tok;
    int unsigned len;
    int unsigned r;
    text.delete();
    n_tok = ($urandom_range(0, 7) == 0) ? 32'(tl) + $urandom_range(0, 2)
                                        : $urandom_range(1, 8);
    if (n_tok > 40) n_tok = 40;
    for (int unsigned t = 0; t < n_tok; t++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        text.push_back("(");
      end else if (r < 24) begin
        text.push_back(")");
      end else if (r < 32) begin
        text.push_back(8'hE2); text.push_back(8'h86); text.push_back(8'h92);
      end else if (r < 40) begin
        text.push_back(8'hE2); text.push_back(8'h87); text.push_back(8'h92);
      end else if (r < 48) begin
        text.push_back(8'hE2); text.push_back(8'h88); text.push_back(8'hA7);
      end else if (r < 56) begin
        text.push_back(8'hE2); text.push_back(8'h88); text.push_back(8'hA8);
      end else if (r < 64) begin
        text.push_back(8'hC2); text.push_back(8'hAC);
      end else if (r < 88) begin
        len = ($urandom_range(0, 9) == 0) ? 32'(il) + $urandom_range(0, 1)
                                          : $urandom_range(1, 4);
        text.push_back(rand_alpha());
        for (int unsigned k = 1; k < len; k++) text.push_back(rand_alnum());
        if ($urandom_range(0, 1) == 0) text.push_back(" ");
      end else if (r < 94) begin
        text.push_back(" ");
      end else if (r < 97) begin
        text.push_back(8'($urandom_range(0, 255)));
      end else begin
        text.push_back(($urandom_range(0, 1) == 0) ? 8'hC2 : 8'hE2);
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    r = $urandom_range(0, 15);
    if (r == 0) begin
      text.push_back(8'hC2);
    end else if (r == 1) begin
      text.push_back(8'hE2);
      text.push_back(8'h88);
    end
  endtask

  initial begin
    logic [6:0]  tl;
    logic [5:0]  il;
    int unsigned sent0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every operator, a space and an identifier closed by the final byte
    text = {8'h28, 8'h29, 8'hE2, 8'h86, 8'h92, 8'hE2, 8'h87, 8'h92,
            8'hE2, 8'h88, 8'hA7, 8'hE2, 8'h88, 8'hA8, 8'hC2, 8'hAC,
            8'h20, 8'h61, 8'h5A, 8'h39};
    send_expr();
    text = {8'h00};          // stray zero byte
    send_expr();
    text = {8'hE2, 8'h41};   // broken sequence
    send_expr();
    text = {8'hC2};          // sequence cut by the final byte
    send_expr();
    text = {8'hFF, 8'h28};   // bytes after an error are dropped
    send_expr();

    tl = TOKEN_LIMIT_RESET;
    il = IDENT_LIMIT_RESET;
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        if (ph == 1) begin
          tl = 7'd1;
          il = 6'd1;
        end else if (ph == 2) begin
          tl = 7'd127;
          il = 6'd63;
        end else begin
          tl = 7'($urandom_range(1, 12));
          il = 6'($urandom_range(1, 10));
        end
        drain();
        write_limits(tl, il);
      end
      calm = (ph == 3);
      sent0 = n_bytes;
      if (ph == 2) begin
        // one identifier just past the widest limit
        text.delete();
        text.push_back(rand_alpha());
        repeat (63) text.push_back(rand_alnum());
        send_expr();
        sent0 = n_bytes;
      end
      while (n_bytes - sent0 < PhaseBytes) begin
        make_formula(tl, il);
        send_expr();
      end
    end
    calm = 1'b0;
    drain();

    $display("sent %0d bytes in %0d formulas across %0d limit settings plus the reset ones",
             n_bytes, n_exprs, n_settings);
    $display("checked %0d results, %0d failures, %0d results still owed",
             checked, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // stops a hung run: no item moved on any channel for too long
  initial begin
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no item moved for %0d cycles, %0d results owed", IdleLimit, pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lft_pkg.sv
rtl/lft_step.sv
rtl/lft_outq.sv
rtl/logic_formula_tokenizer.sv
test/token_stream_checker.sv
test/logic_formula_tokenizer_test.sv
